// ----- hw/rtl/lbrw_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
package lbrw_pkg;

  localparam int MAX_LEN_DEF = 1024;
  localparam int SAMPLE_W    = 32;
  localparam int LEN_W       = 11;
  localparam int FIFO_DEPTH  = 2;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample;
    logic                       last_sample;
  } lbrw_in_t;

  typedef struct packed {
    logic [LEN_W-1:0] window_length;
    logic [LEN_W-1:0] longest_length;
    logic             sequence_done;
    logic             overflow;
  } lbrw_out_t;

  typedef enum logic {
    KIND_ABSORB,
    KIND_OVERFLOW
  } lbrw_kind_t;

  // classified word handed from front to back
  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample;
    logic                       last_sample;
    lbrw_kind_t                 kind;
    logic                       neg_limit;
  } lbrw_item_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_POP,
    ST_PUSH,
    ST_FRONT,
    ST_ADV,
    ST_EMIT
  } lbrw_state_t;

endpackage
`default_nettype wire

// ----- hw/rtl/lbrw_front.sv -----
`timescale 1ns / 1ps
`default_nettype none
module lbrw_front import lbrw_pkg::*; #(
  parameter int MAX_LEN = MAX_LEN_DEF
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       in_valid,
  output logic                            in_stall,
  input  wire lbrw_in_t                   in_word,
  input  wire logic signed [SAMPLE_W-1:0] range_limit,
  input  wire logic                       fifo_full,
  output logic                            fifo_push,
  output lbrw_item_t                      fifo_item
);

  localparam int PW = $clog2(MAX_LEN + 1);

  logic [PW-1:0] cnt_r, cnt_nxt;
  logic          full_seq;

  assign in_stall  = fifo_full;
  assign fifo_push = in_valid && !fifo_full;
  assign full_seq  = (cnt_r >= PW'(MAX_LEN));

  always_comb begin
    fifo_item.sample      = in_word.sample;
    fifo_item.last_sample = in_word.last_sample;
    fifo_item.kind        = full_seq ? KIND_OVERFLOW : KIND_ABSORB;
    fifo_item.neg_limit   = range_limit[SAMPLE_W-1];
  end

  always_comb begin
    cnt_nxt = cnt_r;
    if (fifo_push) begin
      if (in_word.last_sample) begin
        cnt_nxt = '0;
      end else if (!full_seq) begin
        cnt_nxt = cnt_r + PW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

endmodule
`default_nettype wire

// ----- hw/rtl/lbrw_fifo.sv -----
`timescale 1ns / 1ps
`default_nettype none
module lbrw_fifo import lbrw_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       push,
  input  wire lbrw_item_t push_item,
  output logic            full,
  input  wire logic       pop,
  output logic            not_empty,
  output lbrw_item_t      pop_item
);

  localparam int IW = $clog2(FIFO_DEPTH);

  lbrw_item_t    mem_r [FIFO_DEPTH];
  logic [IW-1:0] wp_r, wp_nxt, rp_r, rp_nxt;
  logic [IW:0]   cnt_r, cnt_nxt;

  assign full      = (cnt_r == (IW+1)'(FIFO_DEPTH));
  assign not_empty = (cnt_r != '0);
  assign pop_item  = mem_r[rp_r];

  always_comb begin
    wp_nxt  = wp_r;
    rp_nxt  = rp_r;
    cnt_nxt = cnt_r;
    if (push) begin
      wp_nxt = (wp_r == IW'(FIFO_DEPTH - 1)) ? '0 : wp_r + IW'(1);
    end
    if (pop) begin
      rp_nxt = (rp_r == IW'(FIFO_DEPTH - 1)) ? '0 : rp_r + IW'(1);
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + (IW+1)'(1);
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - (IW+1)'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wp_r] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

endmodule
`default_nettype wire

// ----- hw/rtl/lbrw_back.sv -----
`timescale 1ns / 1ps
`default_nettype none
module lbrw_back import lbrw_pkg::*; #(
  parameter int MAX_LEN = MAX_LEN_DEF
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic signed [SAMPLE_W-1:0] range_limit,
  input  wire logic                       item_valid,
  input  wire lbrw_item_t                 item,
  output logic                            item_pop,
  output logic                            out_valid,
  input  wire logic                       out_stall,
  output lbrw_out_t                       out_word
);

  localparam int PW = $clog2(MAX_LEN + 1);
  localparam int AW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;

  lbrw_state_t state_r, state_nxt;
  lbrw_item_t  item_r, item_nxt;

  logic [PW-1:0] min_head_r, min_head_nxt, min_tail_r, min_tail_nxt;
  logic [PW-1:0] max_head_r, max_head_nxt, max_tail_r, max_tail_nxt;
  logic [PW-1:0] left_r, left_nxt, next_r, next_nxt, best_r, best_nxt;
  logic          ovf_r, ovf_nxt;
  logic          min_done_r, min_done_nxt, max_done_r, max_done_nxt;
  logic          out_valid_r, out_valid_nxt;
  lbrw_out_t     out_r, out_nxt;

  logic [AW-1:0]              min_pos_mem [MAX_LEN];
  logic signed [SAMPLE_W-1:0] min_val_mem [MAX_LEN];
  logic [AW-1:0]              max_pos_mem [MAX_LEN];
  logic signed [SAMPLE_W-1:0] max_val_mem [MAX_LEN];
  logic [AW-1:0]              min_pos_q, max_pos_q;
  logic signed [SAMPLE_W-1:0] min_val_q, max_val_q;
  logic [PW-1:0]              min_ra_full, max_ra_full;
  logic                       wr_en;

  logic                       out_free, shrink;
  logic signed [SAMPLE_W:0]   span;
  logic [PW-1:0]              win, best_upd;
  logic [31:0]                win_ext, long_ext;

  assign out_free  = !out_valid_r || !out_stall;
  assign out_valid = out_valid_r;
  assign out_word  = out_r;

  // window span at 33 bits, shrink while it exceeds the limit
  assign span   = (SAMPLE_W+1)'(max_val_q) - (SAMPLE_W+1)'(min_val_q);
  assign shrink = (left_r + PW'(1) < next_r) && (span > (SAMPLE_W+1)'(range_limit));
  assign win      = next_r - left_r;
  assign best_upd = (win > best_r) ? win : best_r;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (item_valid) begin
          state_nxt = (item.kind == KIND_OVERFLOW) ? ST_EMIT : ST_POP;
        end
      end
      ST_POP: begin
        if (min_done_nxt && max_done_nxt) state_nxt = ST_PUSH;
      end
      ST_PUSH:  state_nxt = item_r.neg_limit ? ST_EMIT : ST_FRONT;
      ST_FRONT: state_nxt = ST_ADV;
      ST_ADV: begin
        if (!shrink) state_nxt = ST_EMIT;
      end
      ST_EMIT: begin
        if (out_free) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    item_nxt      = item_r;
    min_head_nxt  = min_head_r;
    min_tail_nxt  = min_tail_r;
    max_head_nxt  = max_head_r;
    max_tail_nxt  = max_tail_r;
    left_nxt      = left_r;
    next_nxt      = next_r;
    best_nxt      = best_r;
    ovf_nxt       = ovf_r;
    min_done_nxt  = min_done_r;
    max_done_nxt  = max_done_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_nxt       = out_r;
    item_pop      = 1'b0;
    wr_en         = 1'b0;
    win_ext       = 32'(win);
    long_ext      = 32'(best_upd);
    case (state_r)
      ST_IDLE: begin
        if (item_valid) begin
          item_pop     = 1'b1;
          item_nxt     = item;
          min_done_nxt = (min_tail_r == min_head_r);
          max_done_nxt = (max_tail_r == max_head_r);
        end
      end
      ST_POP: begin
        // back entry is in the read register; drop it if the new sample dominates
        if (!min_done_r) begin
          if (min_val_q > item_r.sample) begin
            min_tail_nxt = min_tail_r - PW'(1);
            min_done_nxt = (min_tail_nxt == min_head_r);
          end else begin
            min_done_nxt = 1'b1;
          end
        end
        if (!max_done_r) begin
          if (max_val_q < item_r.sample) begin
            max_tail_nxt = max_tail_r - PW'(1);
            max_done_nxt = (max_tail_nxt == max_head_r);
          end else begin
            max_done_nxt = 1'b1;
          end
        end
      end
      ST_PUSH: begin
        wr_en        = 1'b1;
        min_tail_nxt = min_tail_r + PW'(1);
        max_tail_nxt = max_tail_r + PW'(1);
        next_nxt     = next_r + PW'(1);
      end
      ST_ADV: begin
        if (shrink) begin
          if (PW'(min_pos_q) == left_r) min_head_nxt = min_head_r + PW'(1);
          if (PW'(max_pos_q) == left_r) max_head_nxt = max_head_r + PW'(1);
          left_nxt = left_r + PW'(1);
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          out_valid_nxt         = 1'b1;
          out_nxt.sequence_done = item_r.last_sample;
          if (item_r.kind == KIND_OVERFLOW) begin
            ovf_nxt                = 1'b1;
            out_nxt.window_length  = '0;
            out_nxt.longest_length = LEN_W'(best_r);
            out_nxt.overflow       = 1'b1;
          end else if (item_r.neg_limit) begin
            out_nxt.window_length  = '0;
            out_nxt.longest_length = '0;
            out_nxt.overflow       = ovf_r;
          end else begin
            best_nxt               = best_upd;
            out_nxt.window_length  = win_ext[LEN_W-1:0];
            out_nxt.longest_length = long_ext[LEN_W-1:0];
            out_nxt.overflow       = ovf_r;
          end
          if (item_r.last_sample) begin
            min_head_nxt = '0;
            min_tail_nxt = '0;
            max_head_nxt = '0;
            max_tail_nxt = '0;
            left_nxt     = '0;
            next_nxt     = '0;
            best_nxt     = '0;
            ovf_nxt      = 1'b0;
          end
        end
      end
      default: ;
    endcase
  end

  // pop search reads the back entry, otherwise the front entry
  always_comb begin
    if (state_r == ST_IDLE || state_r == ST_POP) begin
      min_ra_full = min_tail_nxt - PW'(1);
      max_ra_full = max_tail_nxt - PW'(1);
    end else begin
      min_ra_full = min_head_nxt;
      max_ra_full = max_head_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      min_pos_mem[min_tail_r[AW-1:0]] <= next_r[AW-1:0];
      min_val_mem[min_tail_r[AW-1:0]] <= item_r.sample;
      max_pos_mem[max_tail_r[AW-1:0]] <= next_r[AW-1:0];
      max_val_mem[max_tail_r[AW-1:0]] <= item_r.sample;
    end
    min_pos_q <= min_pos_mem[min_ra_full[AW-1:0]];
    min_val_q <= min_val_mem[min_ra_full[AW-1:0]];
    max_pos_q <= max_pos_mem[max_ra_full[AW-1:0]];
    max_val_q <= max_val_mem[max_ra_full[AW-1:0]];
  end

  always_ff @(posedge clk) begin
    item_r <= item_nxt;
    out_r  <= out_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      min_head_r  <= '0;
      min_tail_r  <= '0;
      max_head_r  <= '0;
      max_tail_r  <= '0;
      left_r      <= '0;
      next_r      <= '0;
      best_r      <= '0;
      ovf_r       <= 1'b0;
      min_done_r  <= 1'b0;
      max_done_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      min_head_r  <= min_head_nxt;
      min_tail_r  <= min_tail_nxt;
      max_head_r  <= max_head_nxt;
      max_tail_r  <= max_tail_nxt;
      left_r      <= left_nxt;
      next_r      <= next_nxt;
      best_r      <= best_nxt;
      ovf_r       <= ovf_nxt;
      min_done_r  <= min_done_nxt;
      max_done_r  <= max_done_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule
`default_nettype wire

// ----- hw/rtl/longest_bounded_range_window_core.sv -----
// Longest bounded-range window: for each signed sample word, reports the length of the
// longest window ending there whose max minus min stays within range_limit, and the
// longest such length so far in the sequence; a negative limit gives zero lengths, and
// words past MAX_LEN in a sequence are flagged as overflow. A front stage classifies
// words into a two-word queue; the back engine walks min/max monotone queues held in
// single-port-read memories. A word drops dominated entries from the queue backs,
// pushes itself and, under a non-negative limit, advances the left edge while the span
// exceeds the limit; overflowed words skip the queues. Drops and steps amortize to at
// most one each per word; the back engine finishes one word before it takes the next.
// range_limit must be written only while the block is idle; the block does not check.
`timescale 1ns / 1ps
`default_nettype none
module longest_bounded_range_window_core import lbrw_pkg::*; #(
  parameter int MAX_LEN = MAX_LEN_DEF
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       in_valid,
  output logic                            in_stall,
  input  wire lbrw_in_t                   in_word,
  output logic                            out_valid,
  input  wire logic                       out_stall,
  output lbrw_out_t                       out_word,
  input  wire logic                       cfg_we,
  input  wire logic signed [SAMPLE_W-1:0] cfg_wdata
);

  logic signed [SAMPLE_W-1:0] range_limit_r;
  logic       fifo_full, fifo_push, fifo_pop, fifo_ne;
  lbrw_item_t push_item, pop_item;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      range_limit_r <= '0;
    end else if (cfg_we) begin
      range_limit_r <= cfg_wdata;
    end
  end

  lbrw_front #(.MAX_LEN(MAX_LEN)) u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_word     (in_word),
    .range_limit (range_limit_r),
    .fifo_full   (fifo_full),
    .fifo_push   (fifo_push),
    .fifo_item   (push_item)
  );

  lbrw_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (fifo_push),
    .push_item (push_item),
    .full      (fifo_full),
    .pop       (fifo_pop),
    .not_empty (fifo_ne),
    .pop_item  (pop_item)
  );

  lbrw_back #(.MAX_LEN(MAX_LEN)) u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .range_limit (range_limit_r),
    .item_valid  (fifo_ne),
    .item        (pop_item),
    .item_pop    (fifo_pop),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_word    (out_word)
  );

  a_win_le_longest: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_word.window_length <= out_word.longest_length)
    else $error("window length above longest length");

  a_win_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_word.overflow && !range_limit_r[SAMPLE_W-1]
      |-> out_word.window_length != '0)
    else $error("empty window with non-negative limit");

  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    fifo_pop |-> fifo_ne)
    else $error("back engine took a word from an empty queue");

endmodule
`default_nettype wire
